// File: rtl/u8sd_pkg.sv
// shared types and constants for the utf-8 stream decoder
// depends on nothing; used by u8sd_front, u8sd_back and the top level
`default_nettype none

package u8sd_pkg;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 31;
   localparam int LEN_W   = 3;
   localparam int DATA_W  = 7;

   localparam logic [CP_W-1:0] REPL_CP     = 31'h000_FFFD;
   localparam logic [CP_W-1:0] SURR_LO     = 31'h000_D800;
   localparam logic [CP_W-1:0] SURR_HI     = 31'h000_DFFF;
   localparam logic [CP_W-1:0] NONCHAR_LO  = 31'h000_FFFE;
   localparam logic [CP_W-1:0] NONCHAR_HI  = 31'h000_FFFF;
   localparam logic [CP_W-1:0] MIN_LEN2    = 31'h000_0080;
   localparam logic [CP_W-1:0] MIN_LEN3    = 31'h000_0800;
   localparam logic [CP_W-1:0] MIN_LEN4    = 31'h001_0000;
   localparam logic [CP_W-1:0] MIN_LEN5    = 31'h020_0000;
   localparam logic [CP_W-1:0] MIN_LEN6    = 31'h400_0000;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_ASCII,
      KIND_LEAD,
      KIND_CONT,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            end_of_text;
      logic            last;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/u8sd_queue.sv
// small shift queue; the oldest entry always sits in slot zero
// generic, no package dependency
`default_nettype none

module u8sd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [WIDTH-1:0] slot_in [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] wr_pos;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[0];
   assign wr_pos    = count_ff - CNT_W'(do_pop);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (do_pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
      if (do_push) begin
         slot_in[wr_pos[IDX_W-1:0]] = push_data;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/u8sd_front.sv
// front end: classifies each raw byte into a decode command
// depends on u8sd_pkg
`default_nettype none

module u8sd_front (
   input  wire logic [u8sd_pkg::BYTE_W-1:0] in_byte,
   output u8sd_pkg::cmd_type                cmd
);

   always_comb begin
      cmd.kind = u8sd_pkg::KIND_BAD;
      cmd.len  = '0;
      cmd.data = '0;
      case (in_byte) inside
         8'h00: begin
            cmd.kind = u8sd_pkg::KIND_ZERO;
         end
         [8'h01:8'h7F]: begin
            cmd.kind = u8sd_pkg::KIND_ASCII;
            cmd.data = in_byte[6:0];
         end
         [8'h80:8'hBF]: begin
            cmd.kind = u8sd_pkg::KIND_CONT;
            cmd.data = {1'b0, in_byte[5:0]};
         end
         [8'hC0:8'hDF]: begin
            cmd.kind = u8sd_pkg::KIND_LEAD;
            cmd.len  = 3'd2;
            cmd.data = {2'b0, in_byte[4:0]};
         end
         [8'hE0:8'hEF]: begin
            cmd.kind = u8sd_pkg::KIND_LEAD;
            cmd.len  = 3'd3;
            cmd.data = {3'b0, in_byte[3:0]};
         end
         [8'hF0:8'hF7]: begin
            cmd.kind = u8sd_pkg::KIND_LEAD;
            cmd.len  = 3'd4;
            cmd.data = {4'b0, in_byte[2:0]};
         end
         [8'hF8:8'hFB]: begin
            cmd.kind = u8sd_pkg::KIND_LEAD;
            cmd.len  = 3'd5;
            cmd.data = {5'b0, in_byte[1:0]};
         end
         [8'hFC:8'hFD]: begin
            cmd.kind = u8sd_pkg::KIND_LEAD;
            cmd.len  = 3'd6;
            cmd.data = {6'b0, in_byte[0]};
         end
         default: begin
            cmd.kind = u8sd_pkg::KIND_BAD;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/u8sd_back.sv
// back end: holds the running sequence state, checks values, builds results
// depends on u8sd_pkg
`default_nettype none

module u8sd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire u8sd_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_wr,
   output u8sd_pkg::rsp_type      rsp
);

   logic [u8sd_pkg::CP_W-1:0]  pv_ff, pv_in;
   logic [u8sd_pkg::LEN_W-1:0] pend_ff, pend_in;
   logic [u8sd_pkg::LEN_W-1:0] slen_ff, slen_in;
   logic [u8sd_pkg::CP_W-1:0]  cont_bits;
   logic [u8sd_pkg::CP_W-1:0]  acc;
   logic [u8sd_pkg::CP_W-1:0]  lead_val;
   logic                       go;

   function automatic logic value_ok(input logic [u8sd_pkg::CP_W-1:0] v,
                                     input logic [u8sd_pkg::LEN_W-1:0] len);
      logic ok;
      ok = 1'b1;
      case (len)
         3'd2: ok = (v >= u8sd_pkg::MIN_LEN2);
         3'd3: ok = (v >= u8sd_pkg::MIN_LEN3)
                    && !(v >= u8sd_pkg::SURR_LO && v <= u8sd_pkg::SURR_HI)
                    && (v != u8sd_pkg::NONCHAR_LO) && (v != u8sd_pkg::NONCHAR_HI);
         3'd4: ok = (v >= u8sd_pkg::MIN_LEN4);
         3'd5: ok = (v >= u8sd_pkg::MIN_LEN5);
         3'd6: ok = (v >= u8sd_pkg::MIN_LEN6);
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

   always_comb begin
      case (pend_ff)
         3'd2:    cont_bits = u8sd_pkg::CP_W'(cmd.data[5:0]) << 6;
         3'd3:    cont_bits = u8sd_pkg::CP_W'(cmd.data[5:0]) << 12;
         3'd4:    cont_bits = u8sd_pkg::CP_W'(cmd.data[5:0]) << 18;
         3'd5:    cont_bits = u8sd_pkg::CP_W'(cmd.data[5:0]) << 24;
         default: cont_bits = u8sd_pkg::CP_W'(cmd.data[5:0]);
      endcase
      case (cmd.len)
         3'd3:    lead_val = u8sd_pkg::CP_W'(cmd.data) << 12;
         3'd4:    lead_val = u8sd_pkg::CP_W'(cmd.data) << 18;
         3'd5:    lead_val = u8sd_pkg::CP_W'(cmd.data) << 24;
         3'd6:    lead_val = u8sd_pkg::CP_W'(cmd.data) << 30;
         default: lead_val = u8sd_pkg::CP_W'(cmd.data) << 6;
      endcase
   end

   assign acc = pv_ff | cont_bits;
   assign go  = cmd_valid && !rsp_full;

   always_comb begin
      pv_in   = pv_ff;
      pend_in = pend_ff;
      slen_in = slen_ff;
      cmd_pop = 1'b0;
      rsp_wr  = 1'b0;
      rsp     = '0;
      if (go) begin
         case (cmd.kind)
            u8sd_pkg::KIND_ZERO: begin
               pv_in           = '0;
               pend_in         = '0;
               slen_in         = '0;
               rsp_wr          = 1'b1;
               rsp.end_of_text = 1'b1;
               rsp.last        = 1'b1;
               cmd_pop         = 1'b1;
            end
            u8sd_pkg::KIND_CONT: begin
               cmd_pop = 1'b1;
               if (pend_ff == '0) begin
                  rsp_wr         = 1'b1;
                  rsp.code_point = u8sd_pkg::REPL_CP;
                  rsp.replaced   = 1'b1;
                  rsp.last       = 1'b1;
               end else if (pend_ff == 3'd1) begin
                  pv_in    = '0;
                  pend_in  = '0;
                  slen_in  = '0;
                  rsp_wr   = 1'b1;
                  rsp.last = 1'b1;
                  if (value_ok(acc, slen_ff)) begin
                     rsp.code_point = acc;
                  end else begin
                     rsp.code_point = u8sd_pkg::REPL_CP;
                     rsp.replaced   = 1'b1;
                  end
               end else begin
                  pv_in   = acc;
                  pend_in = pend_ff - 3'd1;
               end
            end
            default: begin
               if (pend_ff != '0) begin
                  // broken sequence; the byte stays queued unless it is a lead
                  pv_in          = '0;
                  pend_in        = '0;
                  slen_in        = '0;
                  rsp_wr         = 1'b1;
                  rsp.code_point = u8sd_pkg::REPL_CP;
                  rsp.replaced   = 1'b1;
                  rsp.last       = (cmd.kind == u8sd_pkg::KIND_LEAD);
                  if (cmd.kind == u8sd_pkg::KIND_LEAD) begin
                     pv_in   = lead_val;
                     pend_in = cmd.len - 3'd1;
                     slen_in = cmd.len;
                     cmd_pop = 1'b1;
                  end
               end else begin
                  cmd_pop = 1'b1;
                  case (cmd.kind)
                     u8sd_pkg::KIND_ASCII: begin
                        rsp_wr         = 1'b1;
                        rsp.code_point = u8sd_pkg::CP_W'(cmd.data);
                        rsp.last       = 1'b1;
                     end
                     u8sd_pkg::KIND_LEAD: begin
                        pv_in   = lead_val;
                        pend_in = cmd.len - 3'd1;
                        slen_in = cmd.len;
                     end
                     default: begin
                        rsp_wr         = 1'b1;
                        rsp.code_point = u8sd_pkg::REPL_CP;
                        rsp.replaced   = 1'b1;
                        rsp.last       = 1'b1;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= '0;
         pend_ff <= '0;
         slen_ff <= '0;
      end else begin
         pv_ff   <= pv_in;
         pend_ff <= pend_in;
         slen_ff <= slen_in;
      end
   end

`ifndef SYNTHESIS
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd5)
      else $error("pending count out of range");
   a_idle_len: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == '0) |-> (slen_ff == '0))
      else $error("sequence length left over while idle");
   a_len_pend: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> (slen_ff > pend_ff))
      else $error("sequence length not above pending count");
   a_no_wr_full: assert property (@(posedge clock) disable iff (reset)
      rsp_wr |-> !rsp_full)
      else $error("result written into full queue");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder_top.sv
// channel   direction  handshake         payload
// req       in         push / full       req_in_byte
// rsp       out        empty / pop       rsp_code_point, rsp_replaced, rsp_end_of_text, rsp_last
//
// one byte per cycle enters while req_full is low; a byte that breaks a sequence
// and gives two results stays in the command queue until its second result is written
// from push to rsp_empty low a byte passes the command queue and then the result queue
// reset clears the sequence state and both queues
// either side may stall on its own; the two queues absorb the difference
// depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back
`default_nettype none

module utf8_stream_decoder_top #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [u8sd_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [u8sd_pkg::CP_W-1:0]          rsp_code_point,
   output logic                               rsp_replaced,
   output logic                               rsp_end_of_text,
   output logic                               rsp_last
);

   localparam int CMD_W = $bits(u8sd_pkg::cmd_type);
   localparam int RSP_W = $bits(u8sd_pkg::rsp_type);

   u8sd_pkg::cmd_type front_cmd;
   u8sd_pkg::cmd_type head_cmd;
   u8sd_pkg::rsp_type back_rsp;
   u8sd_pkg::rsp_type head_rsp;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              rsp_full;
   logic              rsp_wr;
   logic [CMD_W-1:0]  head_cmd_bits;
   logic [RSP_W-1:0]  head_rsp_bits;

   u8sd_front u_front (
      .in_byte (req_in_byte),
      .cmd     (front_cmd)
   );

   u8sd_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .head_data (head_cmd_bits),
      .empty     (cmd_empty)
   );

   assign head_cmd = u8sd_pkg::cmd_type'(head_cmd_bits);

   u8sd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_wr    (rsp_wr),
      .rsp       (back_rsp)
   );

   u8sd_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_wr),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .head_data (head_rsp_bits),
      .empty     (rsp_empty)
   );

   assign head_rsp        = u8sd_pkg::rsp_type'(head_rsp_bits);
   assign rsp_code_point  = head_rsp.code_point;
   assign rsp_replaced    = head_rsp.replaced;
   assign rsp_end_of_text = head_rsp.end_of_text;
   assign rsp_last        = head_rsp.last;

endmodule

`default_nettype wire

// File: verif/utf8_stream_decoder_top_tb.sv
// testbench for utf8_stream_decoder_top: byte stream in, decoded code points out
// predicts every result from its own decoder state and checks each transfer in order
// depends on u8sd_pkg and utf8_stream_decoder_top

module utf8_stream_decoder_top_tb;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 250;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic [u8sd_pkg::BYTE_W-1:0]   req_in_byte = '0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [u8sd_pkg::CP_W-1:0]     rsp_code_point;
   logic                          rsp_replaced;
   logic                          rsp_end_of_text;
   logic                          rsp_last;

   u8sd_pkg::rsp_type decoded_q[$];
   u8sd_pkg::rsp_type step_results[$];
   u8sd_pkg::rsp_type want;
   logic [30:0]       seq_value = '0;
   logic [2:0]        seq_pending = '0;
   logic [2:0]        seq_len = '0;
   int                fail_count = 0;
   int                burst_left = 0;
   int                hold_request = 0;
   logic              idle_on = 1'b1;

   utf8_stream_decoder_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic u8sd_pkg::rsp_type make_rsp(logic [30:0] cp, logic rep, logic eot);
      u8sd_pkg::rsp_type r;
      r.code_point  = cp;
      r.replaced    = rep;
      r.end_of_text = eot;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic void add_step(u8sd_pkg::rsp_type r);
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic logic value_legal(logic [30:0] v, logic [2:0] len);
      case (len)
         3'd2: return v >= u8sd_pkg::MIN_LEN2;
         3'd3: return v >= u8sd_pkg::MIN_LEN3 &&
                      !(v >= u8sd_pkg::SURR_LO && v <= u8sd_pkg::SURR_HI) &&
                      v != u8sd_pkg::NONCHAR_LO && v != u8sd_pkg::NONCHAR_HI;
         3'd4: return v >= u8sd_pkg::MIN_LEN4;
         3'd5: return v >= u8sd_pkg::MIN_LEN5;
         3'd6: return v >= u8sd_pkg::MIN_LEN6;
         default: return 1'b1;
      endcase
   endfunction

   function automatic void clear_seq();
      seq_value   = '0;
      seq_pending = '0;
      seq_len     = '0;
   endfunction

   task automatic open_lead(input logic [7:0] b);
      if (!b[7]) begin
         add_step(make_rsp(31'(b), 1'b0, 1'b0));
      end else if (b[7:5] == 3'b110) begin
         seq_value = 31'(b[4:0]) << 6;
         seq_pending = 3'd1;
         seq_len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         seq_value = 31'(b[3:0]) << 12;
         seq_pending = 3'd2;
         seq_len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         seq_value = 31'(b[2:0]) << 18;
         seq_pending = 3'd3;
         seq_len = 3'd4;
      end else if (b[7:2] == 6'b111110) begin
         seq_value = 31'(b[1:0]) << 24;
         seq_pending = 3'd4;
         seq_len = 3'd5;
      end else if (b[7:1] == 7'b1111110) begin
         seq_value = 31'(b[0]) << 30;
         seq_pending = 3'd5;
         seq_len = 3'd6;
      end else begin
         add_step(make_rsp(u8sd_pkg::REPL_CP, 1'b1, 1'b0));
      end
   endtask

   task automatic decode_byte(input logic [7:0] b);
      logic [30:0]       v;
      logic [2:0]        len;
      int                sh;
      u8sd_pkg::rsp_type r;
      step_results.delete();
      if (b == 8'h00) begin
         clear_seq();
         add_step(make_rsp('0, 1'b0, 1'b1));
      end else if (seq_pending == 0) begin
         open_lead(b);
      end else if (b[7:6] == 2'b10) begin
         sh = 6 * (seq_pending - 1);
         seq_value = seq_value | (31'(b[5:0]) << sh);
         seq_pending = seq_pending - 3'd1;
         if (seq_pending == 0) begin
            v = seq_value;
            len = seq_len;
            clear_seq();
            if (value_legal(v, len))
               add_step(make_rsp(v, 1'b0, 1'b0));
            else
               add_step(make_rsp(u8sd_pkg::REPL_CP, 1'b1, 1'b0));
         end
      end else begin
         clear_seq();
         add_step(make_rsp(u8sd_pkg::REPL_CP, 1'b1, 1'b0));
         open_lead(b);
      end
      foreach (step_results[i]) begin
         r = step_results[i];
         r.last = (i == step_results.size() - 1);
         decoded_q.insert(decoded_q.size(), r);
      end
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = idle_on ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      decode_byte(b);
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] text[$]);
      foreach (text[i]) send_byte(text[i]);
   endtask

   task automatic wait_all_done();
      req_push <= 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [30:0] random_value(int len);
      logic [30:0] v;
      logic [30:0] lo;
      int          r;
      case (len)
         2: lo = u8sd_pkg::MIN_LEN2;
         3: lo = u8sd_pkg::MIN_LEN3;
         4: lo = u8sd_pkg::MIN_LEN4;
         5: lo = u8sd_pkg::MIN_LEN5;
         default: lo = u8sd_pkg::MIN_LEN6;
      endcase
      r = $urandom_range(0, 7);
      if (r == 0) begin
         v = lo + 31'($urandom_range(0, 2)) - 31'd1;
      end else if (r == 1 && len == 3) begin
         case ($urandom_range(0, 5))
            0: v = u8sd_pkg::SURR_LO;
            1: v = u8sd_pkg::SURR_HI;
            2: v = u8sd_pkg::SURR_LO - 31'd1;
            3: v = u8sd_pkg::NONCHAR_LO;
            4: v = u8sd_pkg::NONCHAR_HI;
            default: v = u8sd_pkg::REPL_CP;
         endcase
      end else begin
         v = 31'($urandom) & 31'((32'd1 << (5 * len + 1)) - 1);
      end
      return v;
   endfunction

   task automatic test_random_text(input int n_items);
      logic [7:0]  text[$];
      logic [7:0]  prefix;
      logic [30:0] v;
      int          sent;
      int          pick;
      int          len;
      int          keep;
      sent = 0;
      while (sent < n_items) begin
         text.delete();
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            text.insert(text.size(), 8'($urandom_range(1, 127)));
         end else if (pick < 80) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: len = 2;
               4, 5, 6: len = 3;
               7: len = 4;
               8: len = 5;
               default: len = 6;
            endcase
            case (len)
               2: prefix = 8'hC0;
               3: prefix = 8'hE0;
               4: prefix = 8'hF0;
               5: prefix = 8'hF8;
               default: prefix = 8'hFC;
            endcase
            v = random_value(len);
            text.insert(text.size(), prefix | 8'(v >> (6 * (len - 1))));
            for (int k = len - 2; k >= 0; k--)
               text.insert(text.size(), 8'h80 | (8'(v >> (6 * k)) & 8'h3F));
            // cut the sequence short so the next byte breaks it
            if (pick >= 70) begin
               keep = $urandom_range(1, len - 1);
               while (text.size() > keep) void'(text.pop_back());
            end
         end else if (pick < 85) begin
            text.insert(text.size(), 8'h00);
         end else begin
            text.insert(text.size(), 8'($urandom_range(1, 255)));
         end
         send_text(text);
         sent += text.size();
      end
   endtask

   task automatic test_plain_bytes();
      send_text('{8'h41, 8'h00, 8'h80, 8'hFF});
   endtask

   task automatic test_rejected_forms();
      // overlong, surrogate, noncharacter
      send_text('{8'hC1, 8'hBF});
      send_text('{8'hED, 8'hB0, 8'h80});
      send_text('{8'hEF, 8'hBF, 8'hBE});
   endtask

   task automatic test_broken_sequences();
      // lead inside a sequence, then zero byte inside a sequence
      send_text('{8'hE2, 8'hC3, 8'hA9});
      send_text('{8'hF0, 8'h90, 8'h00});
   endtask

   task automatic test_longest_form();
      send_text('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF});
   endtask

   task automatic test_full_backpressure();
      logic saved;
      saved = idle_on;
      idle_on = 1'b0;
      hold_request = HOLD_CYCLES;
      test_random_text(60);
      idle_on = saved;
   endtask

   task automatic test_no_idle(input int n_items);
      idle_on = 1'b0;
      test_random_text(n_items);
      idle_on = 1'b1;
   endtask

   initial begin : receiver
      int   hold_left;
      int   run_left;
      logic popping;
      hold_left = 0;
      run_left = 0;
      popping = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!idle_on) begin
            rsp_pop <= 1'b1;
         end else begin
            if (run_left == 0) begin
               popping = !popping;
               run_left = popping ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            run_left--;
            rsp_pop <= popping;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (decoded_q.size() == 0) begin
            $error("unexpected transfer: code_point %h", rsp_code_point);
            fail_count++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_code_point !== want.code_point) begin
               $error("code_point: expected %h, actual %h", want.code_point, rsp_code_point);
               fail_count++;
            end
            if (rsp_replaced !== want.replaced) begin
               $error("replaced: expected %b, actual %b", want.replaced, rsp_replaced);
               fail_count++;
            end
            if (rsp_end_of_text !== want.end_of_text) begin
               $error("end_of_text: expected %b, actual %b", want.end_of_text,
                      rsp_end_of_text);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("[utf8_stream_decoder_top] ERROR");
      $finish;
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_rejected_forms();
      test_broken_sequences();
      test_longest_form();
      test_random_text(600);
      test_full_backpressure();
      wait_all_done();
      test_no_idle(400);
      test_random_text(500);
      wait_all_done();
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("[utf8_stream_decoder_top] OK");
      else
         $display("[utf8_stream_decoder_top] ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/u8sd_pkg.sv
rtl/u8sd_queue.sv
rtl/u8sd_front.sv
rtl/u8sd_back.sv
rtl/utf8_stream_decoder_top.sv
verif/utf8_stream_decoder_top_tb.sv
